[rtl/core/grpu_pkg.sv]
// ----------------------------------------------------------------------------
// grpu_pkg
// Types, constants and arithmetic helpers for the grain record converter.
// ----------------------------------------------------------------------------
package grpu_pkg;

    localparam int FieldW    = 16;
    localparam int NumInVal  = 11;
    localparam int NumOutVal = 11;
    localparam int InDataW   = FieldW * NumInVal;
    localparam int OutDataW  = FieldW * NumOutVal;

    typedef logic [FieldW-1:0] word_t;

    typedef enum logic
    {
        FUNC_EXPAND   = 1'b0,
        FUNC_COMPRESS = 1'b1
    } func_t;

    localparam word_t MeanOffset = 16'd128;
    localparam word_t FloorLimit = 16'd127;
    localparam word_t LimMin     = 16'd63;
    localparam word_t LimMean    = 16'd31;
    localparam word_t LimMax     = 16'd63;
    localparam word_t LineWide   = 16'd1280;
    localparam word_t LineNarrow = 16'd1024;
    localparam logic [17:0] OffBias  = 18'd1281;
    localparam logic [15:0] Recip3   = 16'hAAAB;   // ceil(2^17 / 3)
    localparam logic [7:0]  Recip5   = 8'd205;     // ceil(2^10 / 5)

    // 3x3 neighbour index to pixel offset, division truncating toward zero
    function automatic word_t idx_to_off(input word_t p, input logic wide);
        logic        neg;
        word_t       a;
        logic [31:0] prod;
        word_t       q;
        word_t       r;
        word_t       qs;
        word_t       rs;
        word_t       qw;
        word_t       w;
        neg  = p[15];
        a    = neg ? word_t'(-p) : p;
        prod = 32'(a) * 32'(Recip3);
        q    = word_t'(prod >> 17);
        r    = a - (q + (q << 1));
        qs   = neg ? word_t'(-q) : q;
        rs   = neg ? word_t'(-r) : r;
        w    = wide ? LineWide : LineNarrow;
        qw   = wide ? word_t'((qs << 10) + (qs << 8)) : word_t'(qs << 10);
        return qw + rs - w - 16'd1;
    endfunction

    // pixel offset on a 1280 line back to a 3x3 index, truncating division
    function automatic word_t off_to_idx(input word_t p);
        logic        neg;
        logic [17:0] t;
        logic [16:0] a;
        logic [8:0]  hi;
        logic [16:0] prod;
        logic [7:0]  q;
        logic [16:0] r;
        word_t       qs;
        word_t       rs;
        t    = {{2{p[15]}}, p} + OffBias;
        neg  = t[17];
        a    = neg ? 17'(-t) : t[16:0];
        hi   = a[16:8];
        prod = 17'(hi) * 17'(Recip5);
        q    = 8'(prod >> 10);
        r    = a - ((17'(q) << 10) + (17'(q) << 8));
        qs   = neg ? word_t'(-word_t'(q)) : word_t'(q);
        rs   = neg ? word_t'(-word_t'(r)) : word_t'(r);
        return rs + (qs + (qs << 1));
    endfunction

    // symmetric clamp of a signed word
    function automatic word_t clamp_sym(input word_t v, input word_t lim);
        word_t nlim;
        nlim = word_t'(-lim);
        if ($signed(v) > $signed(lim))
        begin
            return lim;
        end
        else if ($signed(v) < $signed(nlim))
        begin
            return nlim;
        end
        return v;
    endfunction

endpackage

[rtl/core/grain_record_pack_unpack_top.sv]
// ----------------------------------------------------------------------------
// grain_record_pack_unpack_top
// Converts grain records between compact and long form, one beat per cycle while m_tready is high.
// ----------------------------------------------------------------------------
// Path: an accepted beat passes the input register, conversion logic and
//   result register, in that order, before it shows on the master side.
// Throughput: one beat per cycle, set by the two-register pipeline; both
//   stages advance together whenever the result register is empty or taken.
// Reset: rst_n clears both stage valid flags and sets wide_line to 1.
// ----------------------------------------------------------------------------
module grain_record_pack_unpack_top
(
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration: wide_line
    input  logic                          cfg_wr_en,
    input  logic                          cfg_wr_data,
    // slave side
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // tdata, low bit up: base_min, base_mean, base_max, prev_min_val,
    // next_min_val, prev_mean_val, next_mean_val, prev_max_val,
    // next_max_val, prev_pos, next_pos
    input  logic [grpu_pkg::InDataW-1:0]  s_tdata,
    // tuser: func
    input  logic                          s_tuser,
    // master side
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // tdata, low bit up: min_out, mean_out, max_out, prev_min_out,
    // next_min_out, prev_mean_out, next_mean_out, prev_max_out,
    // next_max_out, prev_pos_out, next_pos_out
    output logic [grpu_pkg::OutDataW-1:0] m_tdata
);
    import grpu_pkg::*;

    logic                wide_line_reg;
    logic                in_valid_reg;
    logic                out_valid_reg;
    logic [InDataW-1:0]  in_data_reg;
    logic                in_func_reg;
    logic [OutDataW-1:0] out_data_reg;
    logic [OutDataW-1:0] out_data_next;
    logic                out_adv;
    logic                in_adv;

    word_t mn, me, mx, pmn, nmn, pme, nme, pmx, nmx, pp, np;
    word_t r_min, r_mean, r_max, r_pmn, r_nmn, r_pme, r_nme, r_pmx, r_nmx;
    word_t r_pp, r_np;
    word_t d_pmn, d_nmn;

    // Advance the result stage when it is empty or being taken; the input
    // stage also advances when it is empty, so a new beat can enter while a result waits to leave.
    assign out_adv  = !out_valid_reg || m_tready;
    assign in_adv   = !in_valid_reg || out_adv;
    assign s_tready = in_adv;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wide_line_reg <= 1'b1;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                wide_line_reg <= cfg_wr_data;
            end
            if (in_adv)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (out_adv)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    // payload: hold while stalled
    always_ff @(posedge clk)
    begin
        if (in_adv && s_tvalid)
        begin
            in_data_reg <= s_tdata;
            in_func_reg <= s_tuser;
        end
        if (out_adv && in_valid_reg)
        begin
            out_data_reg <= out_data_next;
        end
    end

    // unpack the registered record
    assign mn  = in_data_reg[0*FieldW +: FieldW];
    assign me  = in_data_reg[1*FieldW +: FieldW];
    assign mx  = in_data_reg[2*FieldW +: FieldW];
    assign pmn = in_data_reg[3*FieldW +: FieldW];
    assign nmn = in_data_reg[4*FieldW +: FieldW];
    assign pme = in_data_reg[5*FieldW +: FieldW];
    assign nme = in_data_reg[6*FieldW +: FieldW];
    assign pmx = in_data_reg[7*FieldW +: FieldW];
    assign nmx = in_data_reg[8*FieldW +: FieldW];
    assign pp  = in_data_reg[9*FieldW +: FieldW];
    assign np  = in_data_reg[10*FieldW +: FieldW];

    // min deltas are limited from above only
    assign d_pmn = pmn - mn;
    assign d_nmn = nmn - mn;

    always_comb
    begin
        r_min = mn;
        case (func_t'(in_func_reg))
            FUNC_EXPAND:
            begin
                // add the offset back, rebuild absolutes from the deltas and map the position indices to offsets
                r_mean = me + MeanOffset;
                r_max  = mx + MeanOffset;
                r_pmn  = mn + pmn;
                r_nmn  = mn + nmn;
                r_pme  = me + pme + MeanOffset;
                r_nme  = me + nme + MeanOffset;
                r_pmx  = mx + pmx + MeanOffset;
                r_nmx  = mx + nmx + MeanOffset;
                r_pp   = idx_to_off(pp, wide_line_reg);
                r_np   = idx_to_off(np, wide_line_reg);
            end
            FUNC_COMPRESS:
            begin
                // drop the offset, floored at zero, clamp the deltas and map the position offsets to indices
                r_mean = ($signed(me) > $signed(FloorLimit)) ? me - MeanOffset : '0;
                r_max  = ($signed(mx) > $signed(FloorLimit)) ? mx - MeanOffset : '0;
                r_pmn  = ($signed(d_pmn) > $signed(LimMin)) ? LimMin : d_pmn;
                r_nmn  = ($signed(d_nmn) > $signed(LimMin)) ? LimMin : d_nmn;
                r_pme  = clamp_sym(pme - me, LimMean);
                r_nme  = clamp_sym(nme - me, LimMean);
                r_pmx  = clamp_sym(pmx - mx, LimMax);
                r_nmx  = clamp_sym(nmx - mx, LimMax);
                r_pp   = off_to_idx(pp);
                r_np   = off_to_idx(np);
            end
            default:
            begin
                r_mean = '0;
                r_max  = '0;
                r_pmn  = '0;
                r_nmn  = '0;
                r_pme  = '0;
                r_nme  = '0;
                r_pmx  = '0;
                r_nmx  = '0;
                r_pp   = '0;
                r_np   = '0;
            end
        endcase
    end

    assign out_data_next = {r_np, r_pp, r_nmx, r_pmx, r_nme, r_pme,
                            r_nmn, r_pmn, r_max, r_mean, r_min};

    // an accepted beat always lands in the input stage
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> in_valid_reg)
        else $error("accepted beat lost at input stage");

    // a full input stage moves into the result stage when it advances
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && out_adv |=> out_valid_reg)
        else $error("input stage did not reach result stage");

    // the result stage never refills from an empty input stage
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid_reg && out_adv |=> !out_valid_reg)
        else $error("result invented from empty input stage");

    // a stalled result keeps its data
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !m_tready |=> $stable(out_data_reg))
        else $error("stalled result changed");

endmodule
